// ===== design/mctp_pkg.sv =====
// ---------------------------------------------------------------------------
// Motion command token parser package
// Shared types, character codes and helpers for the token parser.
// ---------------------------------------------------------------------------
package mctp_pkg;

   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_L       = 8'h4C;
   localparam logic [7:0] CHAR_R       = 8'h52;
   localparam logic [7:0] CHAR_V       = 8'h56;
   localparam logic [7:0] CHAR_A       = 8'h41;
   localparam logic [7:0] CHAR_S       = 8'h53;
   localparam logic [7:0] CHAR_I       = 8'h49;

   localparam logic [13:0] MAG_MAX = 14'h3FFF;
   localparam logic [15:0] U16_MAX = 16'hFFFF;
   localparam logic [1:0]  COUNT_FULL = 2'd3;

   typedef enum logic [1:0] {
      AXIS_LINEAR = 2'd0,
      AXIS_ROTATE = 2'd1,
      AXIS_VIBRATE = 2'd2,
      AXIS_AUX = 2'd3
   } axis_type;

   typedef enum logic [1:0] {
      TGT_MAG = 2'd0,
      TGT_SPD = 2'd1,
      TGT_INT = 2'd2
   } target_type;

   typedef struct packed {
      logic        execute_now;
      logic [15:0] interval_ms;
      logic [15:0] speed_value;
      logic [13:0] magnitude;
      logic [3:0]  channel_num;
      logic [1:0]  axis_kind;
      logic        ok;
   } rsp_type;

   function automatic logic is_term(input logic [7:0] c);
      is_term = (c == CHAR_SPACE) || (c == CHAR_NEWLINE);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic logic [7:0] upcase(input logic [7:0] c);
      upcase = ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) ? (c - 8'd32) : c;
   endfunction

   function automatic logic [16:0] pow_ten(input logic [2:0] idx);
      case (idx)
         3'd0:    pow_ten = 17'd1;
         3'd1:    pow_ten = 17'd10;
         3'd2:    pow_ten = 17'd100;
         3'd3:    pow_ten = 17'd1000;
         3'd4:    pow_ten = 17'd10000;
         3'd5:    pow_ten = 17'd100000;
         default: pow_ten = 17'd0;
      endcase
   endfunction

endpackage

// ===== design/mctp_token_unit.sv =====
// ---------------------------------------------------------------------------
// Token state unit
// Holds the state of the token being collected, updates it from one
// character a cycle when stepped and forms the result when a terminator arrives.
// ---------------------------------------------------------------------------
module mctp_token_unit #(
   parameter int FRACTION_DIGITS = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       char_in,
   output mctp_pkg::rsp_type result
);

   localparam logic [2:0] FD = 3'(FRACTION_DIGITS);

   logic [1:0]             char_count_ff, char_count_in;
   mctp_pkg::axis_type     kind_ff, kind_in;
   logic [3:0]             channel_ff, channel_in;
   mctp_pkg::target_type   target_ff, target_in;
   logic [2:0]             order_ff, order_in;
   logic [13:0]            mag_ff, mag_in;
   logic [15:0]            speed_ff, speed_in;
   logic [15:0]            interval_ff, interval_in;
   logic                   failed_ff, failed_in;
   logic                   ended_ff, ended_in;

   logic [7:0]  up;
   logic [3:0]  digit;
   logic        frac_en;
   logic [19:0] add;
   logic [20:0] mag_sum;
   logic [20:0] speed_sum;
   logic [19:0] int_sum;
   logic        ok;

   assign up        = mctp_pkg::upcase(char_in);
   assign digit     = 4'(char_in - mctp_pkg::CHAR_ZERO);
   assign frac_en   = (order_ff <= FD);
   assign add       = frac_en ? 20'(digit * mctp_pkg::pow_ten(3'(FD - order_ff))) : 20'd0;
   assign mag_sum   = {7'd0, mag_ff} + {1'b0, add};
   assign speed_sum = {5'd0, speed_ff} + {1'b0, add};
   assign int_sum   = ({4'd0, interval_ff} << 3) + ({4'd0, interval_ff} << 1)
                      + {16'd0, digit};
   assign ok        = !failed_ff && (char_count_ff == mctp_pkg::COUNT_FULL);

   always_comb begin
      result.ok          = ok;
      result.axis_kind   = ok ? kind_ff : 2'd0;
      result.channel_num = ok ? channel_ff : 4'd0;
      result.magnitude   = ok ? mag_ff : 14'd0;
      result.speed_value = ok ? speed_ff : 16'd0;
      result.interval_ms = ok ? interval_ff : 16'd0;
      result.execute_now = (char_in == mctp_pkg::CHAR_NEWLINE);
   end

   always_comb begin
      char_count_in = char_count_ff;
      kind_in       = kind_ff;
      channel_in    = channel_ff;
      target_in     = target_ff;
      order_in      = order_ff;
      mag_in        = mag_ff;
      speed_in      = speed_ff;
      interval_in   = interval_ff;
      failed_in     = failed_ff;
      ended_in      = ended_ff;
      if (mctp_pkg::is_term(char_in)) begin
         char_count_in = 2'd0;
         kind_in       = mctp_pkg::AXIS_LINEAR;
         channel_in    = 4'd0;
         target_in     = mctp_pkg::TGT_MAG;
         order_in      = 3'd1;
         mag_in        = 14'd0;
         speed_in      = 16'd0;
         interval_in   = 16'd0;
         failed_in     = 1'b0;
         ended_in      = 1'b0;
      end else if (ended_ff) begin
         ended_in = 1'b1;
      end else if (char_in == mctp_pkg::CHAR_NUL) begin
         ended_in = 1'b1;
      end else begin
         if (!failed_ff) begin
            if (char_count_ff == 2'd0) begin
               if (up == mctp_pkg::CHAR_L)      kind_in = mctp_pkg::AXIS_LINEAR;
               else if (up == mctp_pkg::CHAR_R) kind_in = mctp_pkg::AXIS_ROTATE;
               else if (up == mctp_pkg::CHAR_V) kind_in = mctp_pkg::AXIS_VIBRATE;
               else if (up == mctp_pkg::CHAR_A) kind_in = mctp_pkg::AXIS_AUX;
               else failed_in = 1'b1;
            end else if (char_count_ff == 2'd1) begin
               if (mctp_pkg::is_digit(char_in)) channel_in = digit;
               else failed_in = 1'b1;
            end else if (mctp_pkg::is_digit(char_in)) begin
               if (target_ff == mctp_pkg::TGT_INT) begin
                  interval_in = (int_sum > 20'(mctp_pkg::U16_MAX)) ?
                                mctp_pkg::U16_MAX : int_sum[15:0];
               end else begin
                  if (frac_en) order_in = order_ff + 3'd1;
                  if (target_ff == mctp_pkg::TGT_MAG) begin
                     mag_in = (mag_sum > 21'(mctp_pkg::MAG_MAX)) ?
                              mctp_pkg::MAG_MAX : mag_sum[13:0];
                  end else begin
                     speed_in = (speed_sum > 21'(mctp_pkg::U16_MAX)) ?
                                mctp_pkg::U16_MAX : speed_sum[15:0];
                  end
               end
            end else begin
               order_in = 3'd1;
               if (up == mctp_pkg::CHAR_S)      target_in = mctp_pkg::TGT_SPD;
               else if (up == mctp_pkg::CHAR_I) target_in = mctp_pkg::TGT_INT;
               else failed_in = 1'b1;
            end
         end
         if (char_count_ff != mctp_pkg::COUNT_FULL) char_count_in = char_count_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_count_ff <= 2'd0;
         kind_ff       <= mctp_pkg::AXIS_LINEAR;
         channel_ff    <= 4'd0;
         target_ff     <= mctp_pkg::TGT_MAG;
         order_ff      <= 3'd1;
         mag_ff        <= 14'd0;
         speed_ff      <= 16'd0;
         interval_ff   <= 16'd0;
         failed_ff     <= 1'b0;
         ended_ff      <= 1'b0;
      end else if (step) begin
         char_count_ff <= char_count_in;
         kind_ff       <= kind_in;
         channel_ff    <= channel_in;
         target_ff     <= target_in;
         order_ff      <= order_in;
         mag_ff        <= mag_in;
         speed_ff      <= speed_in;
         interval_ff   <= interval_in;
         failed_ff     <= failed_in;
         ended_ff      <= ended_in;
      end
   end

endmodule

// ===== design/mctp_rsp_reg.sv =====
// ---------------------------------------------------------------------------
// Result register
// Holds one finished result until the downstream side takes it.
// ---------------------------------------------------------------------------
module mctp_rsp_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  mctp_pkg::rsp_type data_in,
   input  logic              rsp_tready,
   output logic              rsp_tvalid,
   output logic [55:0]       rsp_tdata,
   output logic              free
);

   logic              valid_ff, valid_in;
   mctp_pkg::rsp_type data_ff;

   assign free       = !valid_ff || rsp_tready;
   assign valid_in   = load || (valid_ff && !rsp_tready);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {2'b00, data_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== design/motion_command_token_parser_core.sv =====
// ---------------------------------------------------------------------------
// Motion command token parser core
// The request register holds each character; a terminator's result then goes
// to the result register. One request per cycle unless a terminator waits.
// A terminator waits in the request register only while a result is held.
// Reset: synchronous, active high; clears the token state and both valids.
// ---------------------------------------------------------------------------
module motion_command_token_parser_core #(
   parameter int FRACTION_DIGITS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata    // [0] ok, [2:1] axis_kind, [6:3] channel_num,
                                    // [20:7] magnitude, [36:21] speed_value,
                                    // [52:37] interval_ms, [53] execute_now
);

   logic              req_valid_ff, req_valid_in;
   logic [7:0]        char_ff;
   logic              rsp_free;
   logic              term;
   logic              step;
   logic              accept;
   mctp_pkg::rsp_type result;

   assign term         = mctp_pkg::is_term(char_ff);
   assign step         = req_valid_ff && (!term || rsp_free);
   assign req_tready   = !req_valid_ff || step;
   assign accept       = req_tvalid && req_tready;
   assign req_valid_in = accept || (req_valid_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         char_ff <= req_tdata;
      end
   end

   mctp_token_unit #(
      .FRACTION_DIGITS (FRACTION_DIGITS)
   ) u_token (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .char_in (char_ff),
      .result  (result)
   );

   mctp_rsp_reg u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load       (step && term),
      .data_in    (result),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .free       (rsp_free)
   );

endmodule

// ===== bench/motion_command_token_parser_core_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Motion command token parser core testbench
// Streams character requests into the parser and checks every result
// against a cycle-free token predictor. Directed tokens cover the axis
// letters, letter case, markers, saturation, zero bytes and bad bytes;
// random tokens follow, mostly well formed with random content, with some
// corrupted, short and noise tokens. The sender runs in random bursts and
// the receiver stalls on its own changing pattern.
// ---------------------------------------------------------------------------
module motion_command_token_parser_core_tb;

   localparam int FRAC_DIGITS  = 4;
   localparam int RANDOM_ITEMS = 1900;
   localparam int SETTLE_CYCLES = 8;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] char_in
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;    // [0] ok, [2:1] axis_kind, [6:3] channel_num,
                              // [20:7] magnitude, [36:21] speed_value,
                              // [52:37] interval_ms, [53] execute_now

   motion_command_token_parser_core #(
      .FRACTION_DIGITS(FRAC_DIGITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // token state of the predictor
   logic [1:0]           tok_len;
   mctp_pkg::axis_type   tok_axis;
   logic [3:0]           tok_chan;
   mctp_pkg::target_type tok_target;
   logic [2:0]           tok_place;
   logic [13:0]          tok_mag;
   logic [15:0]          tok_speed;
   logic [15:0]          tok_interval;
   logic                 tok_bad;
   logic                 tok_nul_seen;

   mctp_pkg::rsp_type    expected_tokens[$];
   int                   mismatch_count;
   int                   items_sent;
   int                   burst_left;
   int                   stall_left;
   int                   stall_mode;
   int                   stall_phase;

   logic [7:0]  axis_chars[4] = '{mctp_pkg::CHAR_L, mctp_pkg::CHAR_R,
                                  mctp_pkg::CHAR_V, mctp_pkg::CHAR_A};

   always #4 clock = ~clock;

   function automatic void clear_token_state();
      tok_len      = '0;
      tok_axis     = mctp_pkg::AXIS_LINEAR;
      tok_chan     = '0;
      tok_target   = mctp_pkg::TGT_MAG;
      tok_place    = 3'd1;
      tok_mag      = '0;
      tok_speed    = '0;
      tok_interval = '0;
      tok_bad      = 1'b0;
      tok_nul_seen = 1'b0;
   endfunction

   function automatic int unsigned frac_weight(input logic [2:0] place);
      int unsigned w;
      w = 1;
      for (int k = place; k < FRAC_DIGITS; k++) w = w * 10;
      return w;
   endfunction

   // advance the token by one character; returns 1 when a result is due
   function automatic bit parse_token_char(input logic [7:0] c,
                                           output mctp_pkg::rsp_type r);
      logic [7:0]  u;
      logic [3:0]  d;
      int unsigned sum;
      int unsigned add;
      r = '0;
      if (c == mctp_pkg::CHAR_SPACE || c == mctp_pkg::CHAR_NEWLINE) begin
         if (!tok_bad && tok_len == mctp_pkg::COUNT_FULL) begin
            r.ok          = 1'b1;
            r.axis_kind   = tok_axis;
            r.channel_num = tok_chan;
            r.magnitude   = tok_mag;
            r.speed_value = tok_speed;
            r.interval_ms = tok_interval;
         end
         r.execute_now = (c == mctp_pkg::CHAR_NEWLINE);
         clear_token_state();
         return 1'b1;
      end
      if (tok_nul_seen) return 1'b0;
      if (c == mctp_pkg::CHAR_NUL) begin
         tok_nul_seen = 1'b1;
         return 1'b0;
      end
      u = (c >= mctp_pkg::CHAR_LOWER_A && c <= mctp_pkg::CHAR_LOWER_Z) ? c - 8'd32 : c;
      d = c[3:0];
      if (!tok_bad) begin
         if (tok_len == 2'd0) begin
            case (u)
               mctp_pkg::CHAR_L: tok_axis = mctp_pkg::AXIS_LINEAR;
               mctp_pkg::CHAR_R: tok_axis = mctp_pkg::AXIS_ROTATE;
               mctp_pkg::CHAR_V: tok_axis = mctp_pkg::AXIS_VIBRATE;
               mctp_pkg::CHAR_A: tok_axis = mctp_pkg::AXIS_AUX;
               default:          tok_bad = 1'b1;
            endcase
         end else if (tok_len == 2'd1) begin
            if (c >= mctp_pkg::CHAR_ZERO && c <= mctp_pkg::CHAR_NINE) tok_chan = d;
            else tok_bad = 1'b1;
         end else if (c >= mctp_pkg::CHAR_ZERO && c <= mctp_pkg::CHAR_NINE) begin
            if (tok_target == mctp_pkg::TGT_INT) begin
               sum = tok_interval * 10 + d;
               tok_interval = (sum > mctp_pkg::U16_MAX) ? mctp_pkg::U16_MAX : sum[15:0];
            end else begin
               add = 0;
               if (tok_place <= FRAC_DIGITS) begin
                  add = d * frac_weight(tok_place);
                  tok_place = tok_place + 3'd1;
               end
               if (tok_target == mctp_pkg::TGT_MAG) begin
                  sum = tok_mag + add;
                  tok_mag = (sum > mctp_pkg::MAG_MAX) ? mctp_pkg::MAG_MAX : sum[13:0];
               end else begin
                  sum = tok_speed + add;
                  tok_speed = (sum > mctp_pkg::U16_MAX) ? mctp_pkg::U16_MAX : sum[15:0];
               end
            end
         end else begin
            tok_place = 3'd1;
            if (u == mctp_pkg::CHAR_S) tok_target = mctp_pkg::TGT_SPD;
            else if (u == mctp_pkg::CHAR_I) tok_target = mctp_pkg::TGT_INT;
            else tok_bad = 1'b1;
         end
      end
      if (tok_len < mctp_pkg::COUNT_FULL) tok_len = tok_len + 2'd1;
      return 1'b0;
   endfunction

   task automatic note_mismatch(input string what, input longint unsigned want,
                                input longint unsigned got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t mismatch %s: expected %0h actual %0h", $realtime, what, want, got);
   endtask

   always @(posedge clock) begin
      mctp_pkg::rsp_type predicted;
      mctp_pkg::rsp_type want;
      mctp_pkg::rsp_type got;
      if (!reset) begin
         if (req_tvalid && req_tready)
            if (parse_token_char(req_tdata, predicted)) expected_tokens.push_back(predicted);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[53:0];
            if (expected_tokens.size() == 0) begin
               note_mismatch("unexpected result", 0, rsp_tdata);
            end else begin
               want = expected_tokens.pop_front();
               if (got.ok != want.ok) note_mismatch("ok", want.ok, got.ok);
               if (got.axis_kind != want.axis_kind)
                  note_mismatch("axis_kind", want.axis_kind, got.axis_kind);
               if (got.channel_num != want.channel_num)
                  note_mismatch("channel_num", want.channel_num, got.channel_num);
               if (got.magnitude != want.magnitude)
                  note_mismatch("magnitude", want.magnitude, got.magnitude);
               if (got.speed_value != want.speed_value)
                  note_mismatch("speed_value", want.speed_value, got.speed_value);
               if (got.interval_ms != want.interval_ms)
                  note_mismatch("interval_ms", want.interval_ms, got.interval_ms);
               if (got.execute_now != want.execute_now)
                  note_mismatch("execute_now", want.execute_now, got.execute_now);
               if (rsp_tdata[55:54] != 2'b00) note_mismatch("pad bits", 0, rsp_tdata[55:54]);
            end
         end
      end
   end

   // receiver stall pattern; the mode changes now and then
   always @(negedge clock) begin
      stall_phase++;
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
      if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= (stall_phase % 4 != 3);
            default: begin
               if ($urandom_range(0, 9) == 0) begin
                  stall_left = $urandom_range(1, 7);
                  rsp_tready <= 1'b0;
               end else begin
                  rsp_tready <= 1'b1;
               end
            end
         endcase
      end
   end

   task automatic send_char(input logic [7:0] c);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int k = 0; k < s.len(); k++) send_char(s[k]);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_tokens.size() != 0) @(negedge clock);
   endtask

   task automatic test_axis_letters();
      send_text("l5 ");
      send_text("v31234567\n");
   endtask

   task automatic test_markers();
      send_text("A0S5I99999\n");
      send_text("R7s1S2 ");
   endtask

   task automatic test_zero_byte();
      send_text("L0");
      send_char(mctp_pkg::CHAR_NUL);
      send_text("x ");
   endtask

   task automatic test_bad_bytes();
      send_text("R");
      send_char(8'hFF);
      send_text("5 ");
   endtask

   function automatic logic [7:0] random_digit();
      return mctp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] random_case(input logic [7:0] c);
      return ($urandom_range(0, 1) == 0) ? c : c + 8'd32;
   endfunction

   task automatic send_random_token();
      logic [7:0] tok[$];
      int         kind;
      int         segs;
      kind = $urandom_range(0, 99);
      if (kind < 88) begin
         tok.push_back(random_case(axis_chars[$urandom_range(0, 3)]));
         tok.push_back(random_digit());
         repeat ($urandom_range(0, 6)) tok.push_back(random_digit());
         if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(6, 9)) begin
               tok.push_back(random_case(mctp_pkg::CHAR_S));
               repeat (4) tok.push_back(mctp_pkg::CHAR_NINE);
            end
         end else begin
            segs = $urandom_range(0, 3);
            repeat (segs) begin
               tok.push_back(random_case(($urandom_range(0, 1) == 0) ?
                                         mctp_pkg::CHAR_S : mctp_pkg::CHAR_I));
               repeat ($urandom_range(0, 7)) tok.push_back(random_digit());
            end
         end
         // corrupt, truncate or cut the text with a zero byte
         if (kind >= 70 && kind < 78) begin
            tok[$urandom_range(0, tok.size() - 1)] = 8'($urandom_range(0, 255));
         end else if (kind >= 78 && kind < 82) begin
            while (tok.size() > $urandom_range(0, 2)) void'(tok.pop_back());
         end else if (kind >= 82) begin
            tok.insert($urandom_range(0, tok.size()), mctp_pkg::CHAR_NUL);
            repeat ($urandom_range(0, 3)) tok.push_back(8'($urandom_range(0, 255)));
         end
      end else begin
         repeat ($urandom_range(1, 8)) tok.push_back(8'($urandom_range(0, 255)));
      end
      foreach (tok[k]) send_char(tok[k]);
      send_char(($urandom_range(0, 1) == 0) ? mctp_pkg::CHAR_SPACE : mctp_pkg::CHAR_NEWLINE);
   endtask

   task automatic test_random_tokens(input int target_items);
      bit drained;
      drained = 1'b0;
      while (items_sent < target_items) begin
         send_random_token();
         if (!drained && items_sent > target_items / 2) begin
            wait_for_results();
            drained = 1'b1;
         end
      end
   endtask

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      rsp_tready     = 1'b0;
      mismatch_count = 0;
      items_sent     = 0;
      burst_left     = 0;
      stall_left     = 0;
      stall_mode     = 0;
      stall_phase    = 0;
      clear_token_state();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_axis_letters();
      test_markers();
      test_zero_byte();
      test_bad_bytes();
      test_random_tokens(items_sent + RANDOM_ITEMS);

      wait_for_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (expected_tokens.size() != 0)
         note_mismatch("results missing", 0, expected_tokens.size());
      if (mismatch_count == 0) begin
         $display("PASS motion_command_token_parser_core");
      end else begin
         $display("FAIL motion_command_token_parser_core");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("FAIL motion_command_token_parser_core");
      $finish;
   end

endmodule
